>>> design/rmq_pkg.sv
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared types and codes for the rotation matrix to quaternion unit.
// ---------------------------------------------------------------------------
package rmq_pkg;

    localparam int ELEM_W = 16;
    localparam int N_ELEM = 9;
    localparam int N_COMP = 4;
    // magnitude of a sum or difference of two elements
    localparam int MAG_W  = ELEM_W + 1;

    typedef logic [1:0] t_branch;

    localparam t_branch BR_TRACE = 2'd0;
    localparam t_branch BR_M00   = 2'd1;
    localparam t_branch BR_M11   = 2'd2;
    localparam t_branch BR_M22   = 2'd3;

    // branch and the sign of each of the three divided lanes
    typedef struct packed {
        t_branch    branch;
        logic [2:0] neg;
    } t_side;

    localparam int SIDE_W = $bits(t_side);

endpackage

>>> design/rmq_sqrt_cell.sv
// ---------------------------------------------------------------------------
// rmq_sqrt_cell
// One digit of a restoring integer square root; hands its state onward.
// ---------------------------------------------------------------------------
module rmq_sqrt_cell #(
    parameter int SW = 18,
    parameter int PW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*SW-1:0] i_x,
    input  logic [SW+1:0]   i_rem,
    input  logic [SW-1:0]   i_root,
    input  logic [PW-1:0]   i_pay,
    output logic            o_valid,
    output logic [2*SW-1:0] o_x,
    output logic [SW+1:0]   o_rem,
    output logic [SW-1:0]   o_root,
    output logic [PW-1:0]   o_pay
);

    logic [SW+3:0] n_tmp;
    logic [SW+3:0] n_trial;
    logic          n_ge;

    always_comb begin
        n_tmp   = {i_rem, i_x[2*SW-1 -: 2]};
        n_trial = {2'b00, i_root, 2'b01};
        n_ge    = (n_tmp >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x   <= {i_x[2*SW-3:0], 2'b00};
            o_pay <= i_pay;
            if (n_ge) begin
                o_rem  <= (SW+2)'(n_tmp - n_trial);
                o_root <= {i_root[SW-2:0], 1'b1};
            end else begin
                o_rem  <= (SW+2)'(n_tmp);
                o_root <= {i_root[SW-2:0], 1'b0};
            end
        end
    end

endmodule

>>> design/rmq_div_cell.sv
// ---------------------------------------------------------------------------
// rmq_div_cell
// One quotient bit of restoring division for three lanes sharing a divisor.
// ---------------------------------------------------------------------------
module rmq_div_cell #(
    parameter int SW = 18,
    parameter int NW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [SW-1:0]   i_s,
    input  rmq_pkg::t_side  i_side,
    input  logic [NW-1:0]   i_num [3],
    input  logic [SW-1:0]   i_rem [3],
    input  logic [NW-1:0]   i_quot [3],
    output logic            o_valid,
    output logic [SW-1:0]   o_s,
    output rmq_pkg::t_side  o_side,
    output logic [NW-1:0]   o_num [3],
    output logic [SW-1:0]   o_rem [3],
    output logic [NW-1:0]   o_quot [3]
);

    logic [SW:0] n_t  [3];
    logic [2:0]  n_ge;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_t[k]  = {i_rem[k], i_num[k][NW-1]};
            n_ge[k] = (n_t[k] >= {1'b0, i_s});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_s    <= i_s;
            o_side <= i_side;
            for (int k = 0; k < 3; k++) begin
                o_num[k]  <= {i_num[k][NW-2:0], 1'b0};
                o_quot[k] <= {i_quot[k][NW-2:0], n_ge[k]};
                o_rem[k]  <= n_ge[k] ? SW'(n_t[k] - {1'b0, i_s}) : SW'(n_t[k]);
            end
        end
    end

endmodule

>>> design/rotation_matrix_to_quaternion_unit.sv
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Shepperd conversion of a fixed-point 3x3 rotation matrix to a quaternion.
// ---------------------------------------------------------------------------
// Pipeline: input reg, square root cell chain (one root bit per cell),
// numerator reg, divider cell chain (one quotient bit per cell), output reg.
// Throughput: one item per cycle; a stalled output holds every stage.
// Reset (synchronous, active low) clears every valid bit; data regs keep.
module rotation_matrix_to_quaternion_unit #(
    parameter int FRAC_BITS = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w (16 bits each)
    output logic [63:0]  m_axis_tdata
);

    localparam int EW   = rmq_pkg::ELEM_W;
    localparam int MW   = rmq_pkg::MAG_W;
    localparam int RW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int SW   = (RW + FRAC_BITS + 3) / 2;
    localparam int NW   = (((MW + FRAC_BITS) > SW) ? (MW + FRAC_BITS) : SW) + 1;
    localparam int SATW = ((NW > SW) ? NW : SW) + 1;
    localparam int PW   = 3 * MW + rmq_pkg::SIDE_W;
    localparam longint ONE     = longint'(1) << FRAC_BITS;
    localparam longint LIM_POS = (ONE < 32767) ? ONE : 32767;
    localparam longint LIM_NEG = (ONE < 32768) ? ONE : 32768;

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- stage A: branch, radicand, lane operands -------------
    logic signed [EW-1:0] m [9];
    logic signed [EW+2:0] n_trace, n_comb;
    logic signed [RW:0]   n_rad;
    logic signed [EW+1:0] n_d [3];
    rmq_pkg::t_side       n_side;
    logic [MW-1:0]        n_mag [3];

    always_comb begin
        for (int k = 0; k < rmq_pkg::N_ELEM; k++) begin
            m[k] = s_axis_tdata[k*EW +: EW];
        end
        n_trace = (EW+3)'(m[0]) + (EW+3)'(m[4]) + (EW+3)'(m[8]);
        if (n_trace > 0) begin
            n_side.branch = rmq_pkg::BR_TRACE;
            n_comb = n_trace;
            n_d[0] = (EW+2)'(m[7]) - (EW+2)'(m[5]);
            n_d[1] = (EW+2)'(m[2]) - (EW+2)'(m[6]);
            n_d[2] = (EW+2)'(m[3]) - (EW+2)'(m[1]);
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            n_side.branch = rmq_pkg::BR_M00;
            n_comb = (EW+3)'(m[0]) - (EW+3)'(m[4]) - (EW+3)'(m[8]);
            n_d[0] = (EW+2)'(m[1]) + (EW+2)'(m[3]);
            n_d[1] = (EW+2)'(m[2]) + (EW+2)'(m[6]);
            n_d[2] = (EW+2)'(m[7]) - (EW+2)'(m[5]);
        end else if (m[4] > m[8]) begin
            n_side.branch = rmq_pkg::BR_M11;
            n_comb = (EW+3)'(m[4]) - (EW+3)'(m[0]) - (EW+3)'(m[8]);
            n_d[0] = (EW+2)'(m[1]) + (EW+2)'(m[3]);
            n_d[1] = (EW+2)'(m[5]) + (EW+2)'(m[7]);
            n_d[2] = (EW+2)'(m[2]) - (EW+2)'(m[6]);
        end else begin
            n_side.branch = rmq_pkg::BR_M22;
            n_comb = (EW+3)'(m[8]) - (EW+3)'(m[0]) - (EW+3)'(m[4]);
            n_d[0] = (EW+2)'(m[2]) + (EW+2)'(m[6]);
            n_d[1] = (EW+2)'(m[5]) + (EW+2)'(m[7]);
            n_d[2] = (EW+2)'(m[3]) - (EW+2)'(m[1]);
        end
        n_rad = (RW+1)'(ONE) + (RW+1)'(n_comb);
        for (int k = 0; k < 3; k++) begin
            n_side.neg[k] = n_d[k][EW+1];
            n_mag[k] = n_d[k][EW+1] ? MW'(-n_d[k]) : MW'(n_d[k]);
        end
    end

    logic                 r_a_valid;
    logic [RW-1:0]        r_a_rad;
    logic [PW-1:0]        r_a_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_rad <= (n_rad > 0) ? RW'(n_rad) : '0;
            r_a_pay <= {n_side, n_mag[2], n_mag[1], n_mag[0]};
        end
    end

    // ---------------- square root cell chain -------------------------------
    logic            sq_v    [SW+1];
    logic [2*SW-1:0] sq_x    [SW+1];
    logic [SW+1:0]   sq_rem  [SW+1];
    logic [SW-1:0]   sq_root [SW+1];
    logic [PW-1:0]   sq_pay  [SW+1];

    assign sq_v[0]    = r_a_valid;
    assign sq_x[0]    = (2*SW)'(r_a_rad) << (FRAC_BITS + 2);
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_pay[0]  = r_a_pay;

    for (genvar g = 0; g < SW; g++) begin : g_sqrt
        rmq_sqrt_cell #(.SW(SW), .PW(PW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_x     (sq_x[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_pay   (sq_pay[g]),
            .o_valid (sq_v[g+1]),
            .o_x     (sq_x[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_pay   (sq_pay[g+1])
        );
    end

    // ---------------- numerator build: |d| * ONE + s/2 ---------------------
    logic            r_p_valid;
    logic [SW-1:0]   r_p_s;
    rmq_pkg::t_side  r_p_side;
    logic [NW-1:0]   r_p_num [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= sq_v[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_s    <= sq_root[SW];
            r_p_side <= rmq_pkg::t_side'(sq_pay[SW][PW-1 -: rmq_pkg::SIDE_W]);
            for (int k = 0; k < 3; k++) begin
                r_p_num[k] <= (NW'(sq_pay[SW][k*MW +: MW]) << FRAC_BITS)
                            + NW'(sq_root[SW] >> 1);
            end
        end
    end

    // ---------------- divider cell chain -----------------------------------
    logic            dv_v    [NW+1];
    logic [SW-1:0]   dv_s    [NW+1];
    rmq_pkg::t_side  dv_side [NW+1];
    logic [NW-1:0]   dv_num  [NW+1][3];
    logic [SW-1:0]   dv_rem  [NW+1][3];
    logic [NW-1:0]   dv_quot [NW+1][3];

    assign dv_v[0]    = r_p_valid;
    assign dv_s[0]    = r_p_s;
    assign dv_side[0] = r_p_side;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dv_num[0][k]  = r_p_num[k];
            dv_rem[0][k]  = '0;
            dv_quot[0][k] = '0;
        end
    end

    for (genvar g = 0; g < NW; g++) begin : g_div
        rmq_div_cell #(.SW(SW), .NW(NW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[g]),
            .i_s     (dv_s[g]),
            .i_side  (dv_side[g]),
            .i_num   (dv_num[g]),
            .i_rem   (dv_rem[g]),
            .i_quot  (dv_quot[g]),
            .o_valid (dv_v[g+1]),
            .o_s     (dv_s[g+1]),
            .o_side  (dv_side[g+1]),
            .o_num   (dv_num[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_quot  (dv_quot[g+1])
        );
    end

    // ---------------- saturation and output register -----------------------
    function automatic logic [15:0] sat16(input logic [SATW-1:0] u, input logic neg);
        logic [SATW-1:0] v;
        if (neg) begin
            v = (u > SATW'(LIM_NEG)) ? SATW'(LIM_NEG) : u;
            return 16'(-v);
        end else begin
            v = (u > SATW'(LIM_POS)) ? SATW'(LIM_POS) : u;
            return 16'(v);
        end
    endfunction

    logic [SW-1:0]   fs;
    rmq_pkg::t_side  fside;
    logic [15:0]     n_q [3];
    logic [15:0]     n_own;
    logic [15:0]     n_x, n_y, n_z, n_w;

    always_comb begin
        fs    = dv_s[NW];
        fside = dv_side[NW];
        for (int k = 0; k < 3; k++) begin
            n_q[k] = sat16(SATW'(dv_quot[NW][k]), fside.neg[k]);
        end
        n_own = sat16((SATW'(fs) + SATW'(2)) >> 2, 1'b0);
        case (fside.branch)
            rmq_pkg::BR_TRACE: begin
                n_x = n_q[0]; n_y = n_q[1]; n_z = n_q[2]; n_w = n_own;
            end
            rmq_pkg::BR_M00: begin
                n_x = n_own;  n_y = n_q[0]; n_z = n_q[1]; n_w = n_q[2];
            end
            rmq_pkg::BR_M11: begin
                n_x = n_q[0]; n_y = n_own;  n_z = n_q[1]; n_w = n_q[2];
            end
            default: begin
                n_x = n_q[0]; n_y = n_q[1]; n_z = n_own;  n_w = n_q[2];
            end
        endcase
        if (fs == '0) begin
            n_x = '0; n_y = '0; n_z = '0; n_w = '0;
        end
    end

    logic        r_o_valid;
    logic [63:0] r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= dv_v[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_data <= {n_w, n_z, n_y, n_x};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

    // ---------------- assertions -------------------------------------------
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_a_valid) && $stable(r_p_valid))
        else $error("pipeline moved while stalled");

    a_zero_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && dv_v[NW] && fs == '0 |=> m_axis_tdata == 64'd0)
        else $error("zero root gave nonzero quaternion");

endmodule

>>> sim/tb_rotation_matrix_to_quaternion_unit.sv
// ---------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_unit
// Streams rotation matrices through the unit with random gaps and stalls on
// both sides and checks each quaternion against a fixed-point predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class quat_scoreboard;
    logic [63:0] quat_q[$];
    int          errors;

    static function longint isqrt(longint unsigned x);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v >>= 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    static function longint two_sqrt(longint r);
        if (r <= 0) return 0;
        return isqrt(r << 16);
    endfunction

    static function longint div_s(longint d, longint s);
        longint unsigned mag, q;
        if (s == 0) return 0;
        mag = (d < 0 ? -d : d) << 14;
        q = (mag + (s >> 1)) / s;
        if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    static function logic [15:0] sat(longint v);
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    function void note_matrix(logic [143:0] d);
        longint m[9];
        longint tr, s, qx, qy, qz, qw;
        for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
        tr = m[0] + m[4] + m[8];
        if (tr > 0) begin
            s = two_sqrt(16384 + tr);
            qw = (s + 2) >> 2;
            qx = div_s(m[7] - m[5], s);
            qy = div_s(m[2] - m[6], s);
            qz = div_s(m[3] - m[1], s);
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            s = two_sqrt(16384 + m[0] - m[4] - m[8]);
            qw = div_s(m[7] - m[5], s);
            qx = (s + 2) >> 2;
            qy = div_s(m[1] + m[3], s);
            qz = div_s(m[2] + m[6], s);
        end else if (m[4] > m[8]) begin
            s = two_sqrt(16384 + m[4] - m[0] - m[8]);
            qw = div_s(m[2] - m[6], s);
            qx = div_s(m[1] + m[3], s);
            qy = (s + 2) >> 2;
            qz = div_s(m[5] + m[7], s);
        end else begin
            s = two_sqrt(16384 + m[8] - m[0] - m[4]);
            qw = div_s(m[3] - m[1], s);
            qx = div_s(m[2] + m[6], s);
            qy = div_s(m[5] + m[7], s);
            qz = (s + 2) >> 2;
        end
        if (s == 0) begin
            qx = 0; qy = 0; qz = 0; qw = 0;
        end
        quat_q.push_back({sat(qw), sat(qz), sat(qy), sat(qx)});
    endfunction

    function void check_quat(logic [63:0] got);
        logic [63:0] exp_v;
        if (quat_q.size() == 0) begin
            $display("%0t: unexpected item %h", $time, got);
            errors++;
            return;
        end
        exp_v = quat_q.pop_front();
        for (int i = 0; i < 4; i++)
            if (got[16*i +: 16] !== exp_v[16*i +: 16]) begin
                $display("%0t: component %0d expected %h actual %h", $time, i,
                         exp_v[16*i +: 16], got[16*i +: 16]);
                errors++;
            end
    endfunction
endclass

module tb_rotation_matrix_to_quaternion_unit;
    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [63:0]  m_axis_tdata;
    logic         in_done = 0;
    quat_scoreboard sb = new();

    rotation_matrix_to_quaternion_unit dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'(16384);
            1: return -16'sd16384;
            2: return 16'($urandom);
            3: return 16'($urandom_range(0, 400)) - 16'd200;
            default: return 16'($urandom_range(0, 32768)) - 16'd16384;
        endcase
    endfunction

    // rotation-like matrix: near-identity with sign flips per branch
    function automatic logic [143:0] rand_rot();
        logic [143:0] d;
        int br;
        br = $urandom_range(0, 3);
        for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'($urandom_range(0, 12000)) - 16'd6000;
        d[0 +: 16]   = (br == 0 || br == 1) ? 16'(16384 - $urandom_range(0, 6000))
                                            : 16'($urandom_range(0, 16384)) - 16'd16384;
        d[64 +: 16]  = (br == 0 || br == 2) ? 16'(16384 - $urandom_range(0, 6000))
                                            : 16'($urandom_range(0, 16384)) - 16'd16384;
        d[128 +: 16] = (br == 0 || br == 3) ? 16'(16384 - $urandom_range(0, 6000))
                                            : 16'($urandom_range(0, 16384)) - 16'd16384;
        return d;
    endfunction

    // valid stays high into the next item when no gap is drawn
    task automatic send_matrix(logic [143:0] d);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_matrix(d);
    endtask

    initial begin
        logic [143:0] d;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: identity, each branch, ties, extremes, zero, non-rotation
        send_matrix({16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384});
        send_matrix({-16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd0, 16'd16384});
        send_matrix({-16'sd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, -16'sd16384});
        send_matrix({16'd16384, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384});
        send_matrix('0);
        send_matrix({9{16'h8000}});
        send_matrix({9{16'h7FFF}});
        send_matrix({9{16'hFFFF}});
        send_matrix({9{16'h5555}});
        send_matrix({9{16'hAAAA}});
        send_matrix({-16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384});
        send_matrix({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                     16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        send_matrix({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                     16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        for (int n = 0; n < 1600; n++) begin
            if ($urandom_range(0, 3) != 0) d = rand_rot();
            else for (int i = 0; i < 9; i++) d[16*i +: 16] = rand_elem();
            send_matrix(d);
        end
        s_axis_tvalid <= 0;
        in_done <= 1;
    end

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (gap != 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_quat(m_axis_tdata);
        end
    end

    initial begin
        wait (in_done);
        while (sb.quat_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.quat_q.size() == 0)
            $display("[rotation_matrix_to_quaternion_unit] OK");
        else
            $display("[rotation_matrix_to_quaternion_unit] ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[rotation_matrix_to_quaternion_unit] ERROR");
        $finish;
    end
endmodule

>>> filelist.f
design/rmq_pkg.sv
design/rmq_sqrt_cell.sv
design/rmq_div_cell.sv
design/rotation_matrix_to_quaternion_unit.sv
sim/tb_rotation_matrix_to_quaternion_unit.sv
